@@ rtl/core/spl_pkg.sv @@
package spl_pkg;

	// table and field geometry
	localparam int MAX_BANDS   = 64;
	localparam int BAND_W      = 6;
	localparam int BCNT_W      = 7;
	localparam int MAX_REGIONS = 4096;
	localparam int SEC_W       = 13;
	localparam int IDX_W       = 12;
	localparam int LAT_W       = 29;
	localparam int LON_W       = 32;
	localparam int PRE_W       = 19;
	localparam int QUO_W       = 14;
	localparam int PROD_W      = 44;
	localparam int TBL_W       = LAT_W + SEC_W;

	// 2pi in Q5.27, rounded to nearest
	localparam longint TWO_PI = 64'd843314857;

	// quotient by 2pi: ((x >> XHI_LSB) * REC_M) >> QUO_SH, low by at most one
	localparam int              REC_W     = 32;
	localparam int              REC_SHIFT = 61;
	localparam int              XHI_LSB   = PROD_W - REC_W;
	localparam int              QUO_SH    = REC_SHIFT - XHI_LSB;
	localparam longint unsigned REC_M     = (64'd1 << REC_SHIFT) / 64'(TWO_PI);

	// item kinds
	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	// register indexes
	localparam logic REG_BAND_COUNT = 1'b0;

	// classified item passed from front to back
	typedef struct packed {
		logic                    is_query;
		logic [BAND_W-1:0]       idx;
		logic signed [LAT_W-1:0] top;
		logic [SEC_W-1:0]        sectors;
		logic signed [LON_W-1:0] lon;
		logic signed [LAT_W-1:0] lat;
	} op_t;

	// one lookup result
	typedef struct packed {
		logic [IDX_W-1:0]  region;
		logic [BAND_W-1:0] band;
		logic [IDX_W-1:0]  sector;
		logic              below;
	} res_t;

endpackage

@@ rtl/core/spl_ifs.sv @@
interface spl_item_if;
	logic                                  valid;
	logic                                  ready;
	logic                                  kind;
	logic [spl_pkg::BAND_W-1:0]            entry_index;
	logic signed [spl_pkg::LAT_W-1:0]      entry_top_latitude;
	logic [spl_pkg::SEC_W-1:0]             entry_sectors;
	logic signed [spl_pkg::LON_W-1:0]      longitude;
	logic signed [spl_pkg::LAT_W-1:0]      latitude;

	modport source (output valid, kind, entry_index, entry_top_latitude, entry_sectors,
		longitude, latitude, input ready);
	modport sink (input valid, kind, entry_index, entry_top_latitude, entry_sectors,
		longitude, latitude, output ready);
endinterface

interface spl_result_if;
	logic                         valid;
	logic                         ready;
	logic [spl_pkg::IDX_W-1:0]    region_index;
	logic [spl_pkg::BAND_W-1:0]   band_index;
	logic [spl_pkg::IDX_W-1:0]    sector_index;
	logic                         below_all_bands;

	modport source (output valid, region_index, band_index, sector_index, below_all_bands,
		input ready);
	modport sink (input valid, region_index, band_index, sector_index, below_all_bands,
		output ready);
endinterface

@@ rtl/core/spl_front.sv @@
module spl_front (
	input  logic            clk,
	input  logic            arst_n,
	spl_item_if.sink        item,
	output logic            op_vld,
	input  logic            op_rdy,
	output spl_pkg::op_t    op
);

	localparam logic signed [spl_pkg::LON_W:0] TP = (spl_pkg::LON_W+1)'(spl_pkg::TWO_PI);

	spl_pkg::op_t            cls;
	logic signed [spl_pkg::LON_W:0] lon_x;
	logic signed [spl_pkg::LON_W:0] lon_w;
	spl_pkg::op_t            fifo_q [2];
	logic                    wr_ptr_q;
	logic                    rd_ptr_q;
	logic [1:0]              fill_q;
	logic                    push;
	logic                    pop;

	// wrap longitude once into 0..2pi
	always_comb begin
		lon_x = {item.longitude[spl_pkg::LON_W-1], item.longitude};
		if (lon_x < 0) begin
			lon_w = lon_x + TP;
		end else if (lon_x > TP) begin
			lon_w = lon_x - TP;
		end else begin
			lon_w = lon_x;
		end
	end

	// classify the beat; clamp sector count to 1..MAX_REGIONS
	always_comb begin
		cls.is_query = (item.kind == spl_pkg::KIND_QUERY);
		cls.idx      = item.entry_index;
		cls.top      = item.entry_top_latitude;
		if (item.entry_sectors == '0) begin
			cls.sectors = spl_pkg::SEC_W'(1);
		end else if (item.entry_sectors > spl_pkg::SEC_W'(spl_pkg::MAX_REGIONS)) begin
			cls.sectors = spl_pkg::SEC_W'(spl_pkg::MAX_REGIONS);
		end else begin
			cls.sectors = item.entry_sectors;
		end
		cls.lon = lon_w[spl_pkg::LON_W-1:0];
		cls.lat = item.latitude;
	end

	// two-entry queue toward the back end
	assign item.ready = (fill_q != 2'd2);
	assign push       = item.valid && item.ready;
	assign op_vld     = (fill_q != 2'd0);
	assign pop        = op_vld && op_rdy;
	assign op         = fifo_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_ptr_q] <= cls;
	end

endmodule

@@ rtl/core/spl_back.sv @@
module spl_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [spl_pkg::BCNT_W-1:0]  band_count,
	input  logic                        op_vld,
	output logic                        op_rdy,
	input  spl_pkg::op_t                op,
	output logic                        res_vld,
	input  logic                        res_rdy,
	output spl_pkg::res_t               res
);

	typedef enum logic [7:0] {
		ST_IDLE = 8'b00000001,
		ST_CNT  = 8'b00000010,
		ST_SUM  = 8'b00000100,
		ST_MUL  = 8'b00001000,
		ST_REC  = 8'b00010000,
		ST_CHK  = 8'b00100000,
		ST_FIX  = 8'b01000000,
		ST_FIN  = 8'b10000000
	} st_t;

	st_t                              st_q;
	logic [spl_pkg::TBL_W-1:0]        tbl_q [spl_pkg::MAX_BANDS];
	logic [spl_pkg::BAND_W-1:0]       iss_q;
	logic                             iss_on_q;
	logic                             rd_vld_q;
	logic [spl_pkg::BAND_W-1:0]       rd_idx_q;
	logic signed [spl_pkg::LAT_W-1:0] rd_top_q;
	logic [spl_pkg::SEC_W-1:0]        rd_sec_q;
	logic [spl_pkg::BCNT_W-1:0]       b_q;
	logic                             below_q;
	logic [spl_pkg::PRE_W-1:0]        prefix_q;
	logic [spl_pkg::SEC_W-1:0]        cnt_q;
	logic signed [spl_pkg::LAT_W-1:0] lat_q;
	logic signed [spl_pkg::LON_W-1:0] lon_q;
	logic [spl_pkg::PROD_W-1:0]       rem_q;
	logic [spl_pkg::QUO_W-1:0]        quo_q;
	logic                             res_vld_q;
	spl_pkg::res_t                    res_q;

	logic [spl_pkg::BCNT_W-1:0]       n_eff;
	logic [spl_pkg::BCNT_W-1:0]       n_last;
	logic [spl_pkg::BAND_W-1:0]       scan_last;
	logic                             hit;
	logic [spl_pkg::BCNT_W-1:0]       b_inc;
	logic                             pop;
	logic [2*spl_pkg::REC_W-1:0]      rec_prod;
	logic                             rem_ge;
	logic [spl_pkg::IDX_W-1:0]        sec;
	logic [spl_pkg::PRE_W:0]          region_sum;
	logic                             fin_go;

	// band count in use, clamped to 1..MAX_BANDS
	always_comb begin
		if (band_count == '0) begin
			n_eff = spl_pkg::BCNT_W'(1);
		end else if (band_count > spl_pkg::BCNT_W'(spl_pkg::MAX_BANDS)) begin
			n_eff = spl_pkg::BCNT_W'(spl_pkg::MAX_BANDS);
		end else begin
			n_eff = band_count;
		end
	end

	assign n_last    = n_eff - spl_pkg::BCNT_W'(1);
	assign scan_last = (st_q == ST_CNT) ? n_last[spl_pkg::BAND_W-1:0] : b_q[spl_pkg::BAND_W-1:0];
	assign hit       = rd_vld_q && (rd_top_q > lat_q);
	assign b_inc     = b_q + spl_pkg::BCNT_W'(hit);
	assign op_rdy    = (st_q == ST_IDLE);
	assign pop       = op_vld && op_rdy;

	// reciprocal product of the top bits; remainder check for the last step
	assign rec_prod = (2*spl_pkg::REC_W)'(rem_q[spl_pkg::PROD_W-1:spl_pkg::XHI_LSB]) *
		(2*spl_pkg::REC_W)'(spl_pkg::REC_M);
	assign rem_ge   = (rem_q >= spl_pkg::PROD_W'(spl_pkg::TWO_PI));

	// sector clamp and region sum
	always_comb begin
		if (lon_q < 0) begin
			sec = '0;
		end else if (quo_q >= spl_pkg::QUO_W'(cnt_q)) begin
			sec = spl_pkg::IDX_W'(cnt_q - spl_pkg::SEC_W'(1));
		end else begin
			sec = quo_q[spl_pkg::IDX_W-1:0];
		end
		region_sum = (spl_pkg::PRE_W+1)'(prefix_q) + (spl_pkg::PRE_W+1)'(sec);
	end

	assign fin_go = (st_q == ST_FIN) && (!res_vld_q || res_rdy);

	// band table: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (pop && !op.is_query) begin
			tbl_q[op.idx] <= {op.top, op.sectors};
		end
		if (iss_on_q) begin
			{rd_top_q, rd_sec_q} <= tbl_q[iss_q];
			rd_idx_q             <= iss_q;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			iss_q     <= '0;
			iss_on_q  <= 1'b0;
			rd_vld_q  <= 1'b0;
			b_q       <= '0;
			below_q   <= 1'b0;
			prefix_q  <= '0;
			res_vld_q <= 1'b0;
		end else begin
			rd_vld_q <= iss_on_q;

			// read issue walks 0..scan_last
			if (iss_on_q) begin
				if (iss_q == scan_last) begin
					iss_on_q <= 1'b0;
				end else begin
					iss_q <= iss_q + spl_pkg::BAND_W'(1);
				end
			end

			if (fin_go) begin
				res_vld_q <= 1'b1;
			end else if (res_rdy) begin
				res_vld_q <= 1'b0;
			end

			case (st_q)
				ST_IDLE: begin
					if (pop && op.is_query) begin
						iss_q    <= '0;
						iss_on_q <= 1'b1;
						b_q      <= '0;
						below_q  <= 1'b0;
						st_q     <= ST_CNT;
					end
				end
				// count band tops above the latitude
				ST_CNT: begin
					if (rd_vld_q) begin
						if (rd_idx_q == n_last[spl_pkg::BAND_W-1:0]) begin
							if (b_inc == n_eff) begin
								below_q <= 1'b1;
								b_q     <= n_last;
							end else begin
								b_q <= b_inc;
							end
							iss_q    <= '0;
							iss_on_q <= 1'b1;
							prefix_q <= '0;
							st_q     <= ST_SUM;
						end else begin
							b_q <= b_inc;
						end
					end
				end
				// sum sectors of earlier bands, take own count at the band
				ST_SUM: begin
					if (rd_vld_q) begin
						if (rd_idx_q == b_q[spl_pkg::BAND_W-1:0]) begin
							st_q <= ST_MUL;
						end else begin
							prefix_q <= prefix_q + spl_pkg::PRE_W'(rd_sec_q);
						end
					end
				end
				// lon * sectors, estimate, remainder, fix-up
				ST_MUL: begin
					st_q <= ST_REC;
				end
				ST_REC: begin
					st_q <= ST_CHK;
				end
				ST_CHK: begin
					st_q <= ST_FIX;
				end
				ST_FIX: begin
					st_q <= ST_FIN;
				end
				ST_FIN: begin
					if (fin_go) st_q <= ST_IDLE;
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath payload
	always_ff @(posedge clk) begin
		if (pop && op.is_query) begin
			lat_q <= op.lat;
			lon_q <= op.lon;
		end
		if ((st_q == ST_SUM) && rd_vld_q && (rd_idx_q == b_q[spl_pkg::BAND_W-1:0])) begin
			cnt_q <= rd_sec_q;
		end
		if (st_q == ST_MUL) begin
			rem_q <= spl_pkg::PROD_W'(lon_q[spl_pkg::LON_W-2:0]) * spl_pkg::PROD_W'(cnt_q);
		end
		// estimate never exceeds the true quotient and falls short by at most one
		if (st_q == ST_REC) begin
			quo_q <= rec_prod[spl_pkg::QUO_SH+spl_pkg::QUO_W-1:spl_pkg::QUO_SH];
		end
		if (st_q == ST_CHK) begin
			rem_q <= rem_q - spl_pkg::PROD_W'(quo_q) * spl_pkg::PROD_W'(spl_pkg::TWO_PI);
		end
		if ((st_q == ST_FIX) && rem_ge) begin
			quo_q <= quo_q + spl_pkg::QUO_W'(1);
		end
		if (fin_go) begin
			res_q.region <= (region_sum > (spl_pkg::PRE_W+1)'(spl_pkg::MAX_REGIONS - 1)) ?
				spl_pkg::IDX_W'(spl_pkg::MAX_REGIONS - 1) : region_sum[spl_pkg::IDX_W-1:0];
			res_q.band   <= b_q[spl_pkg::BAND_W-1:0];
			res_q.sector <= sec;
			res_q.below  <= below_q;
		end
	end

	assign res_vld = res_vld_q;
	assign res     = res_q;

endmodule

@@ rtl/core/sphere_point_to_region_lookup.sv @@
// Equal-area zonal sphere partition lookup.
// Items arrive on the item channel (valid/ready). A load beat (kind 0) writes
// one band entry: its top latitude and sector count. A query beat (kind 1)
// gives longitude and latitude as signed Q5.27 and Q2.27 radians and yields
// one beat on the result channel with region, band and sector numbers and a
// flag for a latitude below every band top. Loads give no result. band_count
// is set through the APB port at byte address 0; the user must write it only
// while idle, which the block does not enforce. A front end wraps the
// longitude and queues up to two beats; the back end runs them in order. A
// load only writes the table and leaves the back end idle. A query does one
// table read per cycle to count band tops, one per cycle to sum earlier
// sector counts, then the states MUL, REC, CHK and FIX form lon * sectors,
// scale it by a reciprocal of 2pi and correct the quotient. Queries do not
// overlap. The result sits in an output register; while the receiver stalls
// the back end holds its finished query and the queue keeps taking beats
// until full. Reset clears control state and sets band_count to 1. The band
// table is not cleared; entries must be loaded before a query reads them.
module sphere_point_to_region_lookup (
	input  logic         clk,
	input  logic         arst_n,
	spl_item_if.sink     item,
	spl_result_if.source result,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	logic [spl_pkg::BCNT_W-1:0] band_count_q;
	logic                       op_vld;
	logic                       op_rdy;
	spl_pkg::op_t               op;
	logic                       res_vld;
	spl_pkg::res_t              res;

	// configuration register
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_count_q <= spl_pkg::BCNT_W'(1);
		end else if (psel && penable && pwrite && (paddr[2] == spl_pkg::REG_BAND_COUNT)) begin
			band_count_q <= pwdata[spl_pkg::BCNT_W-1:0];
		end
	end

	assign prdata = (paddr[2] == spl_pkg::REG_BAND_COUNT) ? 32'(band_count_q) : 32'd0;

	spl_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.op_vld (op_vld),
		.op_rdy (op_rdy),
		.op     (op)
	);

	spl_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.band_count (band_count_q),
		.op_vld     (op_vld),
		.op_rdy     (op_rdy),
		.op         (op),
		.res_vld    (res_vld),
		.res_rdy    (result.ready),
		.res        (res)
	);

	assign result.valid           = res_vld;
	assign result.region_index    = res.region;
	assign result.band_index      = res.band;
	assign result.sector_index    = res.sector;
	assign result.below_all_bands = res.below;

endmodule

@@ tb/spl_tb_pkg.sv @@
`timescale 1ns / 1ps
package spl_tb_pkg;
	import spl_pkg::*;

	// Tracks the band table, predicts each query's region, and checks result beats in order.
	class region_scoreboard;
		longint      band_top [MAX_BANDS];
		int unsigned band_sectors [MAX_BANDS];
		int unsigned band_count;
		res_t        pending_regions [$];
		int unsigned mismatches;

		function new();
			band_count = 1;
			mismatches = 0;
			foreach (band_top[i]) begin
				band_top[i] = 0;
				band_sectors[i] = 0;
			end
		endfunction

		// count field clamped into 1..MAX_BANDS
		function int unsigned active_bands();
			if (band_count == 0)
				return 1;
			if (band_count > MAX_BANDS)
				return MAX_BANDS;
			return band_count;
		endfunction

		// stored sector count as the lookup sees it
		function int unsigned clamp_sectors(input int unsigned count);
			if (count == 0)
				return 1;
			if (count > MAX_REGIONS)
				return MAX_REGIONS;
			return count;
		endfunction

		function void report(input string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("%s", msg);
		endfunction

		function res_t locate_region(input longint lon, input longint lat);
			res_t        found;
			int unsigned n, band, cnt, sector;
			longint      region, wrapped, quotient;
			logic        below;
			n = active_bands();
			// band = number of tops strictly above the latitude
			band = 0;
			for (int i = 0; i < n; i++)
				if (band_top[i] > lat)
					band++;
			below = (band >= n);
			if (below)
				band = n - 1;
			region = 0;
			for (int i = 0; i < band; i++)
				region += clamp_sectors(band_sectors[i]);
			cnt = clamp_sectors(band_sectors[band]);
			// single wrap into 0..2pi
			wrapped = lon;
			if (wrapped < 0)
				wrapped += TWO_PI;
			else if (wrapped > TWO_PI)
				wrapped -= TWO_PI;
			if (wrapped < 0) begin
				sector = 0;
			end else begin
				quotient = (wrapped * longint'(cnt)) / TWO_PI;
				sector = (quotient >= cnt) ? cnt - 1 : int'(quotient);
			end
			region += sector;
			if (region > MAX_REGIONS - 1)
				region = MAX_REGIONS - 1;
			found.region = region[IDX_W-1:0];
			found.band = band[BAND_W-1:0];
			found.sector = sector[IDX_W-1:0];
			found.below = below;
			return found;
		endfunction

		// loads update the table, queries queue a prediction
		function void note_item(input logic kind, input logic [BAND_W-1:0] idx,
			input logic signed [LAT_W-1:0] top, input logic [SEC_W-1:0] sectors,
			input logic signed [LON_W-1:0] lon, input logic signed [LAT_W-1:0] lat);
			if (kind == KIND_LOAD) begin
				band_top[idx] = top;
				band_sectors[idx] = sectors;
			end else begin
				pending_regions.insert(pending_regions.size(), locate_region(lon, lat));
			end
		endfunction

		function void check_result(input res_t got);
			res_t want;
			if (pending_regions.size() == 0) begin
				report($sformatf("result beat with no query pending: region %0d band %0d sector %0d below %0b",
					got.region, got.band, got.sector, got.below));
				return;
			end
			want = pending_regions.pop_front();
			if (got.region !== want.region || got.band !== want.band ||
				got.sector !== want.sector || got.below !== want.below)
				report($sformatf({"result mismatch: expected region %0d band %0d sector %0d below %0b,",
					" got region %0d band %0d sector %0d below %0b"},
					want.region, want.band, want.sector, want.below,
					got.region, got.band, got.sector, got.below));
		endfunction
	endclass

endpackage

@@ tb/tb_sphere_point_to_region_lookup.sv @@
`timescale 1ns / 1ps
module tb_sphere_point_to_region_lookup;
	import spl_pkg::*;
	import spl_tb_pkg::*;

	localparam int ITEM_TARGET   = 1550;
	localparam int SETTLE_CYCLES = 200;
	localparam int STALL_LIMIT   = 4000;
	localparam int LAT_MAX       = 210828715;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	spl_item_if   item_bus();
	spl_result_if result_bus();

	region_scoreboard regions;
	bit               calm = 1'b0;
	int unsigned      items_sent = 0;
	int unsigned      quiet_cycles = 0;

	sphere_point_to_region_lookup dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_bus),
		.result  (result_bus),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// beat monitor and stall watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_bus.valid && item_bus.ready)
				regions.note_item(item_bus.kind, item_bus.entry_index, item_bus.entry_top_latitude,
					item_bus.entry_sectors, item_bus.longitude, item_bus.latitude);
			if (result_bus.valid && result_bus.ready)
				regions.check_result({result_bus.region_index, result_bus.band_index,
					result_bus.sector_index, result_bus.below_all_bands});
		end
		if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// result receiver stalls at random, except in the calm window
	initial begin
		result_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			result_bus.ready = calm || ($urandom_range(99) >= 13);
		end
	end

	task automatic send_item(input logic kind, input logic [BAND_W-1:0] idx,
		input logic signed [LAT_W-1:0] top, input logic [SEC_W-1:0] sectors,
		input logic signed [LON_W-1:0] lon, input logic signed [LAT_W-1:0] lat);
		@(negedge clk);
		calm = (items_sent >= 600 && items_sent < 800);
		while (!calm && $urandom_range(99) < 13) begin
			item_bus.valid = 1'b0;
			@(negedge clk);
		end
		item_bus.kind = kind;
		item_bus.entry_index = idx;
		item_bus.entry_top_latitude = top;
		item_bus.entry_sectors = sectors;
		item_bus.longitude = lon;
		item_bus.latitude = lat;
		item_bus.valid = 1'b1;
		do @(posedge clk); while (!item_bus.ready);
		items_sent++;
	endtask

	// unused fields carry junk so every bit toggles
	task automatic load_band(input logic [BAND_W-1:0] idx, input logic signed [LAT_W-1:0] top,
		input logic [SEC_W-1:0] sectors);
		send_item(KIND_LOAD, idx, top, sectors, LON_W'($urandom), LAT_W'($urandom));
	endtask

	task automatic query_point(input logic signed [LON_W-1:0] lon,
		input logic signed [LAT_W-1:0] lat);
		send_item(KIND_QUERY, BAND_W'($urandom), LAT_W'($urandom), SEC_W'($urandom), lon, lat);
	endtask

	// APB write, then read back
	task automatic write_band_count(input logic [BCNT_W-1:0] value);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {REG_BAND_COUNT, 2'b00};
		pwdata = 32'(value);
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		regions.band_count = value;
		@(negedge clk);
		penable = 1'b0;
		pwrite = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== 32'(value))
			regions.report($sformatf("band_count readback: expected %0d, got %0d", value, prdata));
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	// drain all results, then let any trailing load finish
	task automatic settle();
		@(negedge clk);
		item_bus.valid = 1'b0;
		while (regions.pending_regions.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic signed [LAT_W-1:0] pick_latitude();
		int unsigned pick;
		pick = $urandom_range(99);
		// hug a band top
		if (pick < 45)
			return LAT_W'(regions.band_top[$urandom_range(0, regions.active_bands() - 1)] +
				$urandom_range(0, 2) - 1);
		if (pick < 85)
			return LAT_W'($urandom_range(0, 2 * LAT_MAX) - LAT_MAX);
		if (pick < 93)
			return $urandom_range(1) ? LAT_W'(LAT_MAX) : LAT_W'(-LAT_MAX);
		return LAT_W'($urandom);
	endfunction

	function automatic logic signed [LON_W-1:0] pick_longitude();
		int unsigned pick, band, cnt;
		longint      base;
		pick = $urandom_range(99);
		// near a sector edge of some band, on either side of the wrap
		if (pick < 30) begin
			band = $urandom_range(0, regions.active_bands() - 1);
			cnt = regions.clamp_sectors(regions.band_sectors[band]);
			base = (longint'($urandom_range(0, cnt)) * TWO_PI) / cnt;
			if ($urandom_range(1))
				base -= TWO_PI;
			return LON_W'(base + $urandom_range(0, 2) - 1);
		end
		if (pick < 60)
			return LON_W'($urandom_range(0, 32'd2529944570)) - 32'd843314857;
		if (pick < 85) begin
			case ($urandom_range(3))
				0: base = 0;
				1: base = TWO_PI;
				2: base = -TWO_PI;
				default: base = 2 * TWO_PI;
			endcase
			return LON_W'(base + $urandom_range(0, 4) - 2);
		end
		return $urandom;
	endfunction

	function automatic logic [SEC_W-1:0] pick_sectors(input int unsigned most);
		if ($urandom_range(99) < 6) begin
			case ($urandom_range(4))
				0: return 13'd0;
				1: return 13'd1;
				2: return 13'd4096;
				3: return 13'd4097;
				default: return 13'h1fff;
			endcase
		end
		return SEC_W'($urandom_range(1, most));
	endfunction

	// load entries 0..n-1, tops descending unless asked otherwise
	task automatic fill_table(input int unsigned n, input bit sorted, input int unsigned most);
		longint      top;
		int unsigned span;
		span = 2 * LAT_MAX / n;
		top = longint'(LAT_MAX) - $urandom_range(0, span);
		for (int i = 0; i < n; i++) begin
			load_band(BAND_W'(i), sorted ? LAT_W'(top) : pick_latitude(), pick_sectors(most));
			top = top - longint'($urandom_range(0, span));
			if (top < -LAT_MAX)
				top = -LAT_MAX;
		end
	endtask

	initial begin
		int unsigned phase, setting, n, most, pick;
		bit          sorted;
		regions = new();
		item_bus.valid = 1'b0;
		item_bus.kind = KIND_LOAD;
		item_bus.entry_index = '0;
		item_bus.entry_top_latitude = '0;
		item_bus.entry_sectors = '0;
		item_bus.longitude = '0;
		item_bus.latitude = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: one band, extremes of latitude and longitude, wrap edges
		load_band(6'd0, LAT_W'(LAT_MAX), 13'd4096);
		load_band(6'd63, LAT_W'(-LAT_MAX), 13'd1);
		query_point(32'd0, LAT_W'(LAT_MAX));
		query_point(-32'sd1, LAT_W'(LAT_MAX - 1));
		query_point(LON_W'(TWO_PI), 29'sd0);
		query_point(LON_W'(TWO_PI + 1), 29'sd0);
		query_point(LON_W'(TWO_PI - 1), 29'sd0);
		query_point(-32'sd843314857, 29'sd0);
		query_point(32'sd1686629713, 29'sd0);
		query_point(32'h8000_0000, LAT_W'(-LAT_MAX));
		query_point(32'h7fff_ffff, 29'h0fff_ffff);
		query_point(LON_W'(TWO_PI / 2), 29'h1000_0000);
		// zero sector count acts as one
		load_band(6'd0, 29'h0fff_ffff, 13'd0);
		query_point(LON_W'(TWO_PI - 1), 29'sd0);
		// oversized sector count clamps to the region limit
		load_band(6'd0, LAT_W'(-LAT_MAX), 13'h1fff);
		query_point(LON_W'(TWO_PI - 1), LAT_W'(LAT_MAX));
		query_point(LON_W'(TWO_PI / 3), LAT_W'(-LAT_MAX));
		query_point(-LON_W'(TWO_PI / 4), LAT_W'(-LAT_MAX - 1));
		settle();

		// random phases, each with its own band count and a freshly loaded table
		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			case (phase)
				0: setting = 64;
				1: setting = 1;
				2: setting = 0;
				3: setting = 127;
				4: setting = 3;
				5: setting = 65;
				default: setting = ($urandom_range(3) == 0) ? $urandom_range(1, 64) :
					$urandom_range(1, 12);
			endcase
			write_band_count(BCNT_W'(setting));
			n = regions.active_bands();
			sorted = ($urandom_range(4) != 0);
			case ($urandom_range(2))
				0: most = 4096 / n;
				1: most = 16;
				default: most = 4096;
			endcase
			fill_table(n, sorted, most);
			repeat (120) begin
				pick = $urandom_range(99);
				if (pick < 8)
					load_band(BAND_W'($urandom_range(0, n - 1)), pick_latitude(), pick_sectors(most));
				else if (pick < 11)
					load_band(BAND_W'($urandom_range(0, MAX_BANDS - 1)), pick_latitude(),
						pick_sectors(most));
				else
					query_point(pick_longitude(), pick_latitude());
			end
			settle();
			phase++;
		end

		if (regions.pending_regions.size() != 0)
			regions.report($sformatf("%0d results never arrived", regions.pending_regions.size()));
		if (regions.mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
